// ===== rtl/dspg_pkg.sv =====
`timescale 1ns / 1ps

package dspg_pkg;

    // Channel count and field widths
    localparam int NUM_CH     = 2;
    localparam int TCLK_W     = 27;
    localparam int SCALE_W    = 32;
    localparam int MAG_W      = 20;
    localparam int PROD_W     = MAG_W + SCALE_W;
    localparam int PERIOD_W   = 16;
    localparam int PULSE_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Binary point of the rate product for whole-degree and Q.4 operands
    localparam int SPEED_FRAC = 16;
    localparam int VEL_FRAC   = 20;

    // Bit-serial divider: one quotient bit per step over the timer clock word
    localparam int DIV_STEPS = TCLK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_CLOCK = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_A     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_B     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MICROSTEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE      = 3'd4;

    // Command codes
    localparam logic [2:0] FUNC_TICK         = 3'd0;
    localparam logic [2:0] FUNC_SET_SPEED    = 3'd1;
    localparam logic [2:0] FUNC_MOVE_ANGLE   = 3'd2;
    localparam logic [2:0] FUNC_SET_VELOCITY = 3'd3;
    localparam logic [2:0] FUNC_STOP         = 3'd4;

    // Kinds of multi-cycle command
    localparam logic [1:0] KIND_SPEED = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_VEL   = 2'd2;

    // Microstep modes
    localparam logic [1:0] MS_EIGHTH       = 2'd0;
    localparam logic [1:0] MS_SIXTEENTH    = 2'd1;
    localparam logic [1:0] MS_THIRTYSECOND = 2'd2;
    localparam logic [1:0] MS_SIXTYFOURTH  = 2'd3;

    // Reset values
    localparam logic [TCLK_W-1:0]  TCLK_RESET  = 27'd4000000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd2349056;
    localparam logic [1:0]         MS_RESET    = MS_THIRTYSECOND;
    localparam logic [1:0]         EN_RESET    = 2'b11;

    // Period clamp
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd800;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'd65535;

    typedef struct packed {
        logic [2:0]              func;
        logic                    motor_select;
        logic [15:0]             speed_whole_dps;
        logic [15:0]             target_angle_deg;
        logic signed [MAG_W-1:0] velocity_q4;
    } cmd_t;

    typedef struct packed {
        logic step_a;
        logic step_b;
        logic dir_a;
        logic dir_b;
        logic enable_n_a;
        logic enable_n_b;
        logic ms1_pin;
        logic ms2_pin;
        logic busy_a;
        logic busy_b;
    } pins_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic       tick;
        logic       stop;
        logic       sel;
        logic       latch;
        logic [1:0] kind;
        logic       mul;
        logic       div_init;
        logic       div_step;
        logic       apply;
        logic       load_out;
    } ctl_t;

    // Datapath status to the controller
    typedef struct packed {
        logic div_last;
    } stat_t;

endpackage

// ===== rtl/dual_step_pulse_generator.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------------
// cmd      | cmd_valid / cmd_ready  | cmd  (func, channel, speed, angle, vel)
// pins     | pins_valid / pins_ready| pins (step, dir, enable, microstep, busy)
// cfg      | cfg_we                 | cfg_addr, cfg_wdata (no wait, no read)
//
// Tick, stop, zero-speed, zero-velocity and unknown codes update state and load the result at acceptance.
// Move runs accept, 20x32 multiply, update.
// Nonzero speed or velocity runs accept, multiply, divider set-up, the bit-serial
// divider (27 steps for the timer clock over the pulse rate) and update.
// Reset (rst_n low, async) restores configuration registers and channel state at once.
// A result beat waits in the output register; a new command is taken when the
// controller is idle and that register is empty or being drained in the same cycle.

module dual_step_pulse_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  dspg_pkg::cmd_t                   cmd,
    output logic                             pins_valid,
    input  logic                             pins_ready,
    output dspg_pkg::pins_t                  pins,
    input  logic                             cfg_we,
    input  logic [dspg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dspg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    dspg_pkg::ctl_t  ctl;
    dspg_pkg::stat_t stat;

    dspg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .pins_valid (pins_valid),
        .pins_ready (pins_ready),
        .stat       (stat),
        .ctl        (ctl)
    );

    dspg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .stat      (stat),
        .pins      (pins)
    );

    // Never take a command while the result beat is stuck
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> (!pins_valid || pins_ready))
        else $error("command taken while result beat is blocked");

    // A tick produces its result beat in the next cycle
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.func == dspg_pkg::FUNC_TICK) |=> pins_valid)
        else $error("tick result beat missing");

    // Hold off commands while the rate is computed
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.mul || ctl.div_init || ctl.div_step) |-> !cmd_ready)
        else $error("command taken during rate computation");

    // At most one state update source per cycle
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.tick, ctl.stop, ctl.apply, ctl.latch}))
        else $error("conflicting channel updates");

endmodule

// ===== rtl/dspg_datapath.sv =====
`timescale 1ns / 1ps

module dspg_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dspg_pkg::cmd_t                   cmd,
    input  logic                             cfg_we,
    input  logic [dspg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dspg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  dspg_pkg::ctl_t                   ctl,
    output dspg_pkg::stat_t                  stat,
    output dspg_pkg::pins_t                  pins
);

    logic [dspg_pkg::TCLK_W-1:0]   tclk_reg;
    logic [dspg_pkg::SCALE_W-1:0]  scale_reg [dspg_pkg::NUM_CH];
    logic [1:0]                    ms_reg;
    logic [1:0]                    en_reg;

    logic [dspg_pkg::PERIOD_W-1:0] period_reg [dspg_pkg::NUM_CH];
    logic [dspg_pkg::PERIOD_W-1:0] phase_reg  [dspg_pkg::NUM_CH];
    logic [dspg_pkg::PULSE_W-1:0]  pulses_reg [dspg_pkg::NUM_CH];
    logic                          forever_reg [dspg_pkg::NUM_CH];
    logic                          running_reg [dspg_pkg::NUM_CH];
    logic                          dir_reg     [dspg_pkg::NUM_CH];

    logic [dspg_pkg::PERIOD_W-1:0] period_next [dspg_pkg::NUM_CH];
    logic [dspg_pkg::PERIOD_W-1:0] phase_next  [dspg_pkg::NUM_CH];
    logic [dspg_pkg::PULSE_W-1:0]  pulses_next [dspg_pkg::NUM_CH];
    logic                          forever_next [dspg_pkg::NUM_CH];
    logic                          running_next [dspg_pkg::NUM_CH];
    logic                          dir_next     [dspg_pkg::NUM_CH];
    logic [dspg_pkg::PERIOD_W-1:0] ph_inc       [dspg_pkg::NUM_CH];
    logic                          step_next    [dspg_pkg::NUM_CH];
    logic                          busy_next    [dspg_pkg::NUM_CH];

    logic                          op_sel_reg;
    logic                          op_dir_reg;
    logic [dspg_pkg::MAG_W-1:0]    op_mag_reg;
    logic [dspg_pkg::PROD_W-1:0]   prod_reg;

    logic [dspg_pkg::SCALE_W-1:0]  rem_reg;
    logic [dspg_pkg::SCALE_W-1:0]  dvs_reg;
    logic [dspg_pkg::TCLK_W-1:0]   quo_reg;
    logic [dspg_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic [dspg_pkg::MAG_W-1:0]    vel_bits;
    logic [dspg_pkg::MAG_W-1:0]    vel_abs;
    logic [dspg_pkg::MAG_W-1:0]    mag;
    logic [dspg_pkg::SCALE_W-1:0]  rate_raw;
    logic [dspg_pkg::SCALE_W-1:0]  rate;
    logic [dspg_pkg::SCALE_W:0]    trial;
    logic [dspg_pkg::SCALE_W:0]    diff;
    logic                          trial_ge;
    logic [dspg_pkg::PERIOD_W-1:0] period_new;
    logic [dspg_pkg::PULSE_W-1:0]  move_pulses;
    logic                          ms1;
    logic                          ms2;
    dspg_pkg::pins_t               pins_next;
    dspg_pkg::pins_t               pins_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tclk_reg     <= dspg_pkg::TCLK_RESET;
            scale_reg[0] <= dspg_pkg::SCALE_RESET;
            scale_reg[1] <= dspg_pkg::SCALE_RESET;
            ms_reg       <= dspg_pkg::MS_RESET;
            en_reg       <= dspg_pkg::EN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dspg_pkg::CFG_TIMER_CLOCK: tclk_reg     <= cfg_wdata[dspg_pkg::TCLK_W-1:0];
                dspg_pkg::CFG_SCALE_A:     scale_reg[0] <= cfg_wdata[dspg_pkg::SCALE_W-1:0];
                dspg_pkg::CFG_SCALE_B:     scale_reg[1] <= cfg_wdata[dspg_pkg::SCALE_W-1:0];
                dspg_pkg::CFG_MICROSTEP:   ms_reg       <= cfg_wdata[1:0];
                dspg_pkg::CFG_ENABLE:      en_reg       <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Select the operand magnitude; velocity takes its absolute value
    always_comb
    begin
        vel_bits = cmd.velocity_q4;
        vel_abs  = vel_bits[dspg_pkg::MAG_W-1] ? (~vel_bits + 1'b1) : vel_bits;
        case (ctl.kind)
            dspg_pkg::KIND_SPEED: mag = dspg_pkg::MAG_W'(cmd.speed_whole_dps);
            dspg_pkg::KIND_MOVE:  mag = dspg_pkg::MAG_W'(cmd.target_angle_deg);
            dspg_pkg::KIND_VEL:   mag = vel_abs;
            default:              mag = '0;
        endcase
    end

    // Hold the operand, then multiply by the channel scale
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            op_sel_reg <= cmd.motor_select;
            op_mag_reg <= mag;
            op_dir_reg <= !vel_bits[dspg_pkg::MAG_W-1];
        end
        if (ctl.mul)
        begin
            prod_reg <= op_mag_reg * scale_reg[op_sel_reg];
        end
    end

    // Drop the fraction bits and raise a zero rate to one
    always_comb
    begin
        if (ctl.kind == dspg_pkg::KIND_VEL)
            rate_raw = prod_reg[dspg_pkg::VEL_FRAC +: dspg_pkg::SCALE_W];
        else
            rate_raw = prod_reg[dspg_pkg::SPEED_FRAC +: dspg_pkg::SCALE_W];
        rate        = (rate_raw == '0) ? dspg_pkg::SCALE_W'(1) : rate_raw;
        move_pulses = prod_reg[dspg_pkg::SPEED_FRAC +: dspg_pkg::PULSE_W];
    end

    // Restoring divider step: timer clock over rate
    always_comb
    begin
        trial    = {rem_reg, quo_reg[dspg_pkg::TCLK_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        trial_ge = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= tclk_reg;
            dvs_reg <= rate;
        end
        else if (ctl.div_step)
        begin
            rem_reg <= trial_ge ? diff[dspg_pkg::SCALE_W-1:0] : trial[dspg_pkg::SCALE_W-1:0];
            quo_reg <= {quo_reg[dspg_pkg::TCLK_W-2:0], trial_ge};
        end
    end

    // Count divider steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctl.div_init)
            cnt_reg <= '0;
        else if (ctl.div_step)
            cnt_reg <= cnt_reg + 1'b1;
    end

    assign stat.div_last = (cnt_reg == dspg_pkg::DIV_CNT_W'(dspg_pkg::DIV_STEPS - 1));

    // Clamp the quotient into the period range
    always_comb
    begin
        if (quo_reg > dspg_pkg::TCLK_W'(dspg_pkg::PERIOD_MAX))
            period_new = dspg_pkg::PERIOD_MAX;
        else if (quo_reg < dspg_pkg::TCLK_W'(dspg_pkg::PERIOD_MIN))
            period_new = dspg_pkg::PERIOD_MIN;
        else
            period_new = quo_reg[dspg_pkg::PERIOD_W-1:0];
    end

    // Channel update: tick, stop and finished commands
    always_comb
    begin
        for (int c = 0; c < dspg_pkg::NUM_CH; c++)
        begin
            period_next[c]  = period_reg[c];
            phase_next[c]   = phase_reg[c];
            pulses_next[c]  = pulses_reg[c];
            forever_next[c] = forever_reg[c];
            running_next[c] = running_reg[c];
            dir_next[c]     = dir_reg[c];
            ph_inc[c]       = dspg_pkg::PERIOD_W'(phase_reg[c] + 1'b1);

            if (ctl.tick && running_reg[c])
            begin
                if (ph_inc[c] >= period_reg[c] || ph_inc[c] == '0)
                begin
                    phase_next[c] = '0;
                    if (!forever_reg[c])
                    begin
                        if (pulses_reg[c] == '0)
                            running_next[c] = 1'b0;
                        else
                            pulses_next[c] = pulses_reg[c] - 1'b1;
                    end
                end
                else
                begin
                    phase_next[c] = ph_inc[c];
                end
            end

            if (ctl.stop && ctl.sel == 1'(c))
            begin
                running_next[c] = 1'b0;
                forever_next[c] = 1'b0;
                pulses_next[c]  = '0;
                phase_next[c]   = '0;
            end

            if (ctl.apply && op_sel_reg == 1'(c))
            begin
                case (ctl.kind)
                    dspg_pkg::KIND_SPEED:
                    begin
                        period_next[c] = period_new;
                    end
                    dspg_pkg::KIND_MOVE:
                    begin
                        pulses_next[c]  = move_pulses;
                        forever_next[c] = 1'b0;
                        running_next[c] = 1'b1;
                    end
                    dspg_pkg::KIND_VEL:
                    begin
                        dir_next[c]     = op_dir_reg;
                        period_next[c]  = period_new;
                        forever_next[c] = 1'b1;
                        pulses_next[c]  = '0;
                        running_next[c] = 1'b1;
                    end
                    default: ;
                endcase
            end

            step_next[c] = running_next[c] && (phase_next[c] < (period_next[c] >> 1));
            busy_next[c] = forever_next[c] || (pulses_next[c] != '0);
        end
    end

    // Advance the channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < dspg_pkg::NUM_CH; c++)
            begin
                period_reg[c]  <= dspg_pkg::PERIOD_MAX;
                phase_reg[c]   <= '0;
                pulses_reg[c]  <= '0;
                forever_reg[c] <= 1'b0;
                running_reg[c] <= 1'b0;
                dir_reg[c]     <= 1'b1;
            end
        end
        else
        begin
            for (int c = 0; c < dspg_pkg::NUM_CH; c++)
            begin
                period_reg[c]  <= period_next[c];
                phase_reg[c]   <= phase_next[c];
                pulses_reg[c]  <= pulses_next[c];
                forever_reg[c] <= forever_next[c];
                running_reg[c] <= running_next[c];
                dir_reg[c]     <= dir_next[c];
            end
        end
    end

    // Decode the microstep pin pattern
    always_comb
    begin
        ms1 = 1'b0;
        ms2 = 1'b0;
        unique case (ms_reg)
            dspg_pkg::MS_EIGHTH:       begin ms1 = 1'b0; ms2 = 1'b0; end
            dspg_pkg::MS_SIXTEENTH:    begin ms1 = 1'b1; ms2 = 1'b1; end
            dspg_pkg::MS_THIRTYSECOND: begin ms1 = 1'b1; ms2 = 1'b0; end
            dspg_pkg::MS_SIXTYFOURTH:  begin ms1 = 1'b0; ms2 = 1'b1; end
            default:                   begin ms1 = 1'b0; ms2 = 1'b0; end
        endcase
    end

    // Build the result beat from the updated state
    always_comb
    begin
        pins_next.step_a     = step_next[0];
        pins_next.step_b     = step_next[1];
        pins_next.dir_a      = dir_next[0];
        pins_next.dir_b      = dir_next[1];
        pins_next.enable_n_a = !en_reg[0];
        pins_next.enable_n_b = !en_reg[1];
        pins_next.ms1_pin    = ms1;
        pins_next.ms2_pin    = ms2;
        pins_next.busy_a     = busy_next[0];
        pins_next.busy_b     = busy_next[1];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
            pins_reg <= pins_next;
    end

    assign pins = pins_reg;

endmodule

// ===== rtl/dspg_ctrl.sv =====
`timescale 1ns / 1ps

module dspg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  dspg_pkg::cmd_t   cmd,
    output logic             pins_valid,
    input  logic             pins_ready,
    input  dspg_pkg::stat_t  stat,
    output dspg_pkg::ctl_t   ctl
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic       valid_reg;
    logic       slot_free;
    logic       accept;

    // The output slot frees when empty or when its beat is taken
    assign slot_free  = !valid_reg || pins_ready;
    assign cmd_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept     = cmd_valid && cmd_ready;
    assign pins_valid = valid_reg;

    // Sequence commands
    always_comb
    begin
        ctl        = '0;
        ctl.kind   = kind_reg;
        ctl.sel    = cmd.motor_select;
        state_next = state_reg;
        kind_next  = kind_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.func)
                        dspg_pkg::FUNC_TICK:
                        begin
                            ctl.tick     = 1'b1;
                            ctl.load_out = 1'b1;
                        end
                        dspg_pkg::FUNC_SET_SPEED:
                        begin
                            if (cmd.speed_whole_dps == '0)
                            begin
                                ctl.stop     = 1'b1;
                                ctl.load_out = 1'b1;
                            end
                            else
                            begin
                                ctl.latch  = 1'b1;
                                ctl.kind   = dspg_pkg::KIND_SPEED;
                                kind_next  = dspg_pkg::KIND_SPEED;
                                state_next = ST_MUL;
                            end
                        end
                        dspg_pkg::FUNC_MOVE_ANGLE:
                        begin
                            ctl.latch  = 1'b1;
                            ctl.kind   = dspg_pkg::KIND_MOVE;
                            kind_next  = dspg_pkg::KIND_MOVE;
                            state_next = ST_MUL;
                        end
                        dspg_pkg::FUNC_SET_VELOCITY:
                        begin
                            if (cmd.velocity_q4 == '0)
                            begin
                                ctl.stop     = 1'b1;
                                ctl.load_out = 1'b1;
                            end
                            else
                            begin
                                ctl.latch  = 1'b1;
                                ctl.kind   = dspg_pkg::KIND_VEL;
                                kind_next  = dspg_pkg::KIND_VEL;
                                state_next = ST_MUL;
                            end
                        end
                        dspg_pkg::FUNC_STOP:
                        begin
                            ctl.stop     = 1'b1;
                            ctl.load_out = 1'b1;
                        end
                        default:
                        begin
                            ctl.load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                ctl.mul = 1'b1;
                if (kind_reg == dspg_pkg::KIND_MOVE)
                    state_next = ST_FIN;
                else
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                ctl.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    ctl.apply    = 1'b1;
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= dspg_pkg::KIND_SPEED;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            if (ctl.load_out)
                valid_reg <= 1'b1;
            else if (pins_ready)
                valid_reg <= 1'b0;
        end
    end

endmodule

// ===== verif/dual_step_pulse_generator_tb.sv =====
`timescale 1ns / 1ps

module dual_step_pulse_generator_tb;
    import dspg_pkg::*;

    localparam int IDLE_PCT       = 37;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [2:0] FUNC_UNUSED_LO = FUNC_STOP + 3'd1;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    localparam logic [MAG_W-1:0] VEL_EDGE [4] = '{20'h80000, 20'h7FFFF, 20'hFFFFF, 20'h00001};

    // Field names of pins_t, indexed by bit position
    localparam string PIN_NAME [10] = '{"busy_b", "busy_a", "ms2_pin", "ms1_pin", "enable_n_b",
                                        "enable_n_a", "dir_b", "dir_a", "step_b", "step_a"};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    cmd_t                  cmd = '0;
    logic                  pins_valid;
    logic                  pins_ready = 1'b0;
    pins_t                 pins;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Register shadow
    logic [TCLK_W-1:0]   reg_tclk;
    logic [SCALE_W-1:0]  reg_scale [NUM_CH];
    logic [1:0]          reg_ms;
    logic [1:0]          reg_en;

    // Channel state of the pin model
    logic [PERIOD_W-1:0] ch_period  [NUM_CH];
    logic [PERIOD_W-1:0] ch_phase   [NUM_CH];
    logic [PULSE_W-1:0]  ch_pulses  [NUM_CH];
    logic                ch_endless [NUM_CH];
    logic                ch_running [NUM_CH];
    logic                ch_dir     [NUM_CH];

    cmd_t  cmd_backlog_q [$];
    pins_t pins_expected_q [$];
    int    mismatch_count = 0;
    int    stall_cycles = 0;
    bit    no_gaps = 1'b0;

    dual_step_pulse_generator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .pins_valid (pins_valid),
        .pins_ready (pins_ready),
        .pins       (pins),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void stop_channel(int ch);
        ch_running[ch] = 1'b0;
        ch_endless[ch] = 1'b0;
        ch_pulses[ch]  = '0;
        ch_phase[ch]   = '0;
    endfunction

    // Turn a pulse rate into a clamped timer period
    function automatic void set_period(int ch, logic [63:0] rate);
        logic [63:0] r;
        logic [63:0] quot;
        r = (rate == 64'd0) ? 64'd1 : rate;
        quot = 64'(reg_tclk) / r;
        if (quot > 64'(PERIOD_MAX))
            quot = 64'(PERIOD_MAX);
        if (quot < 64'(PERIOD_MIN))
            quot = 64'(PERIOD_MIN);
        ch_period[ch] = quot[PERIOD_W-1:0];
    endfunction

    // Advance the phase; at a period end keep running, stop, or count down one pulse
    function automatic void tick_channel(int ch);
        if (!ch_running[ch])
            return;
        ch_phase[ch] = ch_phase[ch] + 16'd1;
        if (ch_phase[ch] >= ch_period[ch] || ch_phase[ch] == 16'd0)
        begin
            ch_phase[ch] = '0;
            if (!ch_endless[ch])
            begin
                if (ch_pulses[ch] == '0)
                    stop_channel(ch);
                else
                    ch_pulses[ch] = ch_pulses[ch] - 32'd1;
            end
        end
    endfunction

    // Apply one command to the channel model and return the pin levels after it
    function automatic pins_t predict_pins(cmd_t c);
        pins_t       p;
        int          ch;
        logic [63:0] prod;
        logic [20:0] mag;
        ch = int'(c.motor_select);
        case (c.func)
            FUNC_TICK:
            begin
                tick_channel(0);
                tick_channel(1);
            end
            FUNC_SET_SPEED:
            begin
                if (c.speed_whole_dps == '0)
                    stop_channel(ch);
                else
                begin
                    prod = 64'(c.speed_whole_dps) * 64'(reg_scale[ch]);
                    set_period(ch, prod >> SPEED_FRAC);
                end
            end
            FUNC_MOVE_ANGLE:
            begin
                prod = 64'(c.target_angle_deg) * 64'(reg_scale[ch]);
                ch_pulses[ch]  = prod[SPEED_FRAC +: PULSE_W];
                ch_endless[ch] = 1'b0;
                ch_running[ch] = 1'b1;
            end
            FUNC_SET_VELOCITY:
            begin
                if (c.velocity_q4 == '0)
                    stop_channel(ch);
                else
                begin
                    mag = c.velocity_q4[MAG_W-1] ? (21'h100000 - {1'b0, c.velocity_q4})
                                                 : {1'b0, c.velocity_q4};
                    ch_dir[ch] = !c.velocity_q4[MAG_W-1];
                    prod = 64'(mag) * 64'(reg_scale[ch]);
                    set_period(ch, prod >> VEL_FRAC);
                    ch_endless[ch] = 1'b1;
                    ch_pulses[ch]  = '0;
                    ch_running[ch] = 1'b1;
                end
            end
            FUNC_STOP:
                stop_channel(ch);
            default:
            begin
            end
        endcase
        p.step_a     = ch_running[0] && (ch_phase[0] < (ch_period[0] >> 1));
        p.step_b     = ch_running[1] && (ch_phase[1] < (ch_period[1] >> 1));
        p.dir_a      = ch_dir[0];
        p.dir_b      = ch_dir[1];
        p.enable_n_a = !reg_en[0];
        p.enable_n_b = !reg_en[1];
        p.ms1_pin    = (reg_ms == MS_SIXTEENTH) || (reg_ms == MS_THIRTYSECOND);
        p.ms2_pin    = (reg_ms == MS_SIXTEENTH) || (reg_ms == MS_SIXTYFOURTH);
        p.busy_a     = ch_endless[0] || (ch_pulses[0] != '0);
        p.busy_b     = ch_endless[1] || (ch_pulses[1] != '0);
        return p;
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] f, logic ch, logic [15:0] spd,
                                      logic [15:0] ang, logic [MAG_W-1:0] vel);
        cmd_t c;
        c.func             = f;
        c.motor_select     = ch;
        c.speed_whole_dps  = spd;
        c.target_angle_deg = ang;
        c.velocity_q4      = vel;
        return c;
    endfunction

    // Random command: ticks at the given share, with operands biased toward zero, small and edge values
    function automatic cmd_t random_cmd(int tick_pct);
        cmd_t c;
        int   r;
        int   m;
        c.motor_select     = 1'($urandom);
        c.speed_whole_dps  = 16'($urandom);
        c.target_angle_deg = 16'($urandom);
        c.velocity_q4      = 20'($urandom);
        r = $urandom_range(99);
        if (r < tick_pct)
            c.func = FUNC_TICK;
        else if ($urandom_range(19) == 0)
            c.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        else
            c.func = 3'($urandom_range(FUNC_SET_SPEED, FUNC_STOP));
        r = $urandom_range(99);
        m = $urandom_range(1, 5000);
        case (c.func)
            FUNC_SET_SPEED:
            begin
                if (r < 12)
                    c.speed_whole_dps = '0;
                else if (r < 60)
                    c.speed_whole_dps = 16'($urandom_range(1, 300));
            end
            FUNC_MOVE_ANGLE:
            begin
                if (r < 15)
                    c.target_angle_deg = '0;
                else if (r < 65)
                    c.target_angle_deg = 16'($urandom_range(1, 12));
            end
            FUNC_SET_VELOCITY:
            begin
                if (r < 12)
                    c.velocity_q4 = '0;
                else if (r < 55)
                    c.velocity_q4 = $urandom_range(1) ? -20'(m) : 20'(m);
                else if (r < 62)
                    c.velocity_q4 = VEL_EDGE[$urandom_range(3)];
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_TIMER_CLOCK: reg_tclk     = data[TCLK_W-1:0];
            CFG_SCALE_A:     reg_scale[0] = data;
            CFG_SCALE_B:     reg_scale[1] = data;
            CFG_MICROSTEP:   reg_ms       = data[1:0];
            CFG_ENABLE:      reg_en       = data[1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued command is taken and every result is back, then linger
    task automatic drain_and_settle();
        do
            @(negedge clk);
        while (cmd_backlog_q.size() != 0 || cmd_valid || pins_expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_random(int count, int tick_pct);
        for (int i = 0; i < count; i++)
            cmd_backlog_q.push_back(random_cmd(tick_pct));
    endtask

    // Command driver: present the next queued beat, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else if (!cmd_valid || cmd_ready)
        begin
            if (cmd_backlog_q.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT))
            begin
                cmd       <= cmd_backlog_q.pop_front();
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Result sink: stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pins_ready <= 1'b0;
        else
            pins_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on each command beat, check each result beat
    always @(posedge clk)
    begin : monitor
        pins_t want;
        bit    moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cmd_valid && cmd_ready)
            begin
                pins_expected_q.push_back(predict_pins(cmd));
                moved = 1'b1;
            end
            if (pins_valid && pins_ready)
            begin
                moved = 1'b1;
                if (pins_expected_q.size() == 0)
                    report_error($sformatf("result beat %b with nothing expected", pins));
                else
                begin
                    want = pins_expected_q.pop_front();
                    for (int i = 0; i < $bits(pins_t); i++)
                    begin
                        if (pins[i] !== want[i])
                            report_error($sformatf("%s got %b want %b", PIN_NAME[i],
                                                   pins[i], want[i]));
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        reg_tclk  = TCLK_RESET;
        reg_scale[0] = SCALE_RESET;
        reg_scale[1] = SCALE_RESET;
        reg_ms    = MS_RESET;
        reg_en    = EN_RESET;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            ch_period[ch]  = PERIOD_MAX;
            ch_phase[ch]   = '0;
            ch_pulses[ch]  = '0;
            ch_endless[ch] = 1'b0;
            ch_running[ch] = 1'b0;
            ch_dir[ch]     = 1'b1;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: every operation, zero and edge operands
        cmd_backlog_q.push_back(make_cmd(FUNC_TICK,         1'b1, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_SPEED,    1'b0, 16'd1,    16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_SPEED,    1'b1, 16'hFFFF, 16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_VELOCITY, 1'b0, 16'd0,    16'd0,    20'h00001));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_VELOCITY, 1'b1, 16'd0,    16'd0,    20'h80000));
        cmd_backlog_q.push_back(make_cmd(FUNC_TICK,         1'b0, 16'd0,    16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_MOVE_ANGLE,   1'b0, 16'd0,    16'hFFFF, 20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_MOVE_ANGLE,   1'b1, 16'd0,    16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_VELOCITY, 1'b1, 16'd0,    16'd0,    20'h7FFFF));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_VELOCITY, 1'b0, 16'd0,    16'd0,    20'hFFFFF));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_SPEED,    1'b0, 16'd0,    16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_VELOCITY, 1'b1, 16'd0,    16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_STOP,         1'b0, 16'd0,    16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_UNUSED_LO,    1'b1, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
        cmd_backlog_q.push_back(make_cmd(FUNC_UNUSED_HI,    1'b0, 16'h5A5A, 16'hA5A5, 20'h5A5A5));
        cmd_backlog_q.push_back(make_cmd(FUNC_TICK,         1'b0, 16'd0,    16'd0,    20'h0));
        drain_and_settle();

        // Zero timer clock, extreme scales, eighth step, both drivers off
        write_reg(CFG_TIMER_CLOCK, 32'd0);
        write_reg(CFG_SCALE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SCALE_B, 32'd0);
        write_reg(CFG_MICROSTEP, 32'(MS_EIGHTH));
        write_reg(CFG_ENABLE, 32'd0);
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_SPEED,    1'b0, 16'hFFFF, 16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_SPEED,    1'b1, 16'd1,    16'd0,    20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_MOVE_ANGLE,   1'b0, 16'd0,    16'hFFFF, 20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_VELOCITY, 1'b1, 16'd0,    16'd0,    20'h80000));
        cmd_backlog_q.push_back(make_cmd(FUNC_TICK,         1'b0, 16'd0,    16'd0,    20'h0));
        push_random(120, 50);
        drain_and_settle();

        // Largest timer clock, random scales, sixty-fourth step; no gaps on either side
        write_reg(CFG_TIMER_CLOCK, 32'hFFFF_FFFF);
        write_reg(CFG_SCALE_A, $urandom);
        write_reg(CFG_SCALE_B, $urandom);
        write_reg(CFG_MICROSTEP, 32'(MS_SIXTYFOURTH));
        write_reg(CFG_ENABLE, 32'd1);
        no_gaps = 1'b1;
        push_random(120, 50);
        drain_and_settle();
        no_gaps = 1'b0;

        // Short periods and small pulse counts so that moves run out and periods end
        write_reg(CFG_TIMER_CLOCK, 32'd1000);
        write_reg(CFG_SCALE_A, 32'h0000_4000);
        write_reg(CFG_SCALE_B, 32'h0001_0000);
        write_reg(CFG_MICROSTEP, 32'(MS_SIXTEENTH));
        write_reg(CFG_ENABLE, 32'd2);
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_SPEED,    1'b0, 16'd4, 16'd0, 20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_MOVE_ANGLE,   1'b0, 16'd0, 16'd1, 20'h0));
        cmd_backlog_q.push_back(make_cmd(FUNC_SET_VELOCITY, 1'b1, 16'd0, 16'd0, 20'h00010));
        push_random(400, 97);

        // Hold the sender until all results are back
        drain_and_settle();
        write_reg(CFG_MICROSTEP, 32'(MS_THIRTYSECOND));
        write_reg(CFG_ENABLE, 32'd3);
        cmd_backlog_q.push_back(make_cmd(FUNC_MOVE_ANGLE, 1'b1, 16'd0, 16'd1, 20'h0));
        push_random(400, 97);
        drain_and_settle();

        if (pins_expected_q.size() != 0)
            report_error($sformatf("%0d results never arrived", pins_expected_q.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
